FILE: sv/fdfb_pkg.sv
// Shared types, command bytes and segment tables for the four-digit display frame builder.
// No dependencies; design modules use scoped names into it; the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package fdfb_pkg;

  // Controller command bytes.
  localparam logic [7:0] CMD_AUTO = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_ON   = 8'h88;

  // Largest number that can be shown.
  localparam logic [15:0] NUM_MAX = 16'd9999;

  // Brightness after reset.
  localparam logic [2:0] BRIGHT_RESET = 3'd7;

  // Function codes of an input item.
  localparam logic FUNC_SHOW  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Byte positions within one request's frames.
  localparam logic [2:0] IDX_AUTO = 3'd0;
  localparam logic [2:0] IDX_ADDR = 3'd1;
  localparam logic [2:0] IDX_D0   = 3'd2;
  localparam logic [2:0] IDX_D1   = 3'd3;
  localparam logic [2:0] IDX_D2   = 3'd4;
  localparam logic [2:0] IDX_D3   = 3'd5;
  localparam logic [2:0] IDX_ON   = 3'd6;

  // Mode codes for the first-digit letter.
  localparam logic [1:0] MODE_A = 2'd0;
  localparam logic [1:0] MODE_L = 2'd1;
  localparam logic [1:0] MODE_E = 2'd2;
  localparam logic [1:0] MODE_S = 2'd3;

  // One decoded request: the four segment bytes and the out-of-range flag.
  typedef struct packed {
    logic            err;
    logic [3:0][7:0] seg;
  } frame_t;

  // Seven-segment code of a decimal digit.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h67;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Letter pattern for the first digit.
  function automatic logic [7:0] letter_of(input logic [1:0] mode);
    logic [7:0] code;
    unique case (mode)
      MODE_A:  code = 8'h77;
      MODE_L:  code = 8'h38;
      MODE_E:  code = 8'h79;
      MODE_S:  code = 8'h6D;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fdfb_if.sv
// Valid/ready channel interfaces for request items and frame-byte items.
// Depends on nothing; used by the decode stage, the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

interface fdfb_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] number;
  logic        [1:0]  mode;

  modport source (output valid, output func, output number, output mode, input ready);
  modport sink   (input valid, input func, input number, input mode, output ready);
endinterface

interface fdfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       start_before;
  logic       stop_after;
  logic       error;
  logic       last;

  modport source (output valid, output frame_byte, output start_before,
                  output stop_after, output error, output last, input ready);
  modport sink   (input valid, input frame_byte, input start_before,
                  input stop_after, input error, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/four_digit_display_frame_builder_unit.sv
// A request item passes the input register and the sequencer's frame register before its
// first byte item is registered in the output register. A show or clear request gives seven
// byte items, one per cycle while the receiver is ready; an out-of-range request gives one
// error item. The sequencer takes the next request as it emits the last item of the current
// one. Reset (rst_n low, synchronous) empties the input register, the sequencer and the
// output register, and sets brightness to 7.
`timescale 1ns / 1ps
`default_nettype none

module four_digit_display_frame_builder_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  fdfb_in_if.sink         in_chan,
  fdfb_out_if.source      out_chan,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  logic [2:0]       brightness_r;
  logic             frame_valid;
  logic             frame_ready;
  fdfb_pkg::frame_t frame;

  // Brightness register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= fdfb_pkg::BRIGHT_RESET;
    end else if (cfg_we) begin
      brightness_r <= cfg_wdata;
    end
  end

  // Input register and digit decode.
  fdfb_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Byte sequencer and output register.
  fdfb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .brightness  (brightness_r),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_chan    (out_chan)
  );

endmodule

`default_nettype wire

FILE: sv/fdfb_decode.sv
// Input register and digit decode: turns a request into four segment bytes.
// Depends on fdfb_pkg and fdfb_in_if.
`timescale 1ns / 1ps
`default_nettype none

module fdfb_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  fdfb_in_if.sink               in_chan,
  output logic                  frame_valid,
  input  wire logic             frame_ready,
  output fdfb_pkg::frame_t      frame
);

  logic               full_r;
  logic               func_r;
  logic signed [15:0] number_r;
  logic        [1:0]  mode_r;

  logic        [13:0] val;
  logic        [17:0] th_split;
  logic        [17:0] hu_split;
  logic        [17:0] te_split;
  logic               out_of_range;

  // Strips up to nine multiples of unit off v; returns {count, remainder}.
  // The nine compares are independent of each other.
  function automatic logic [17:0] split_digit(input logic [13:0] v,
                                              input logic [13:0] unit);
    logic [3:0]  dig;
    logic [13:0] rem;
    logic [13:0] mult;
    dig  = '0;
    rem  = v;
    mult = '0;
    for (int k = 1; k < 10; k++) begin
      mult = 14'(k) * unit;
      if (v >= mult) begin
        dig = 4'(k);
        rem = v - mult;
      end
    end
    return {dig, rem};
  endfunction

  // The input register frees up when its item moves on to the sequencer.
  assign in_chan.ready = !full_r || frame_ready;
  assign frame_valid   = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      full_r <= 1'b1;
    end else if (frame_ready) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      func_r   <= in_chan.func;
      number_r <= in_chan.number;
      mode_r   <= in_chan.mode;
    end
  end

  // Decimal digits of the low 14 bits; the thousands digit is dropped.
  assign val          = number_r[13:0];
  assign th_split     = split_digit(val, 14'd1000);
  assign hu_split     = split_digit(th_split[13:0], 14'd100);
  assign te_split     = split_digit(hu_split[13:0], 14'd10);
  assign out_of_range = number_r[15] || (number_r > $signed(fdfb_pkg::NUM_MAX));

  // A clear request sends blank digits and never reports a range error.
  always_comb begin
    if (func_r == fdfb_pkg::FUNC_CLEAR) begin
      frame.err = 1'b0;
      frame.seg = '0;
    end else begin
      frame.err    = out_of_range;
      frame.seg[0] = fdfb_pkg::letter_of(mode_r);
      frame.seg[1] = fdfb_pkg::seg_of(hu_split[17:14]);
      frame.seg[2] = fdfb_pkg::seg_of(te_split[17:14]);
      frame.seg[3] = fdfb_pkg::seg_of(te_split[3:0]);
    end
  end

endmodule

`default_nettype wire

FILE: sv/fdfb_seq.sv
// Frame sequencer: holds one decoded request and emits its bytes through an output register,
// one per cycle unless the receiver stalls. Depends on fdfb_pkg and fdfb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module fdfb_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [2:0]       brightness,
  input  wire logic             frame_valid,
  output logic                  frame_ready,
  input  wire fdfb_pkg::frame_t frame,
  fdfb_out_if.source            out_chan
);

  logic                 busy_r;
  logic [2:0]           idx_r;
  fdfb_pkg::frame_t     frame_r;
  logic                 out_valid_r;
  logic [7:0]           byte_r;
  logic                 start_r;
  logic                 stop_r;
  logic                 err_r;
  logic                 last_r;

  logic                 emit;
  logic                 last_step;
  logic [7:0]           byte_nxt;
  logic                 start_nxt;
  logic                 stop_nxt;
  logic                 err_nxt;
  logic                 last_nxt;

  // While a request is held, a byte moves into the output register whenever it is empty or being taken.
  assign emit        = busy_r && (!out_valid_r || out_chan.ready);
  assign last_step   = frame_r.err || (idx_r == fdfb_pkg::IDX_ON);
  assign frame_ready = !busy_r || (emit && last_step);

  // Byte and framing flags for the current position.
  always_comb begin
    byte_nxt  = '0;
    start_nxt = 1'b0;
    stop_nxt  = 1'b0;
    err_nxt   = 1'b0;
    last_nxt  = 1'b0;
    if (frame_r.err) begin
      err_nxt  = 1'b1;
      last_nxt = 1'b1;
    end else begin
      unique case (idx_r)
        fdfb_pkg::IDX_AUTO: begin
          byte_nxt  = fdfb_pkg::CMD_AUTO;
          start_nxt = 1'b1;
          stop_nxt  = 1'b1;
        end
        fdfb_pkg::IDX_ADDR: begin
          byte_nxt  = fdfb_pkg::CMD_ADDR;
          start_nxt = 1'b1;
        end
        fdfb_pkg::IDX_D0: byte_nxt = frame_r.seg[0];
        fdfb_pkg::IDX_D1: byte_nxt = frame_r.seg[1];
        fdfb_pkg::IDX_D2: byte_nxt = frame_r.seg[2];
        fdfb_pkg::IDX_D3: begin
          byte_nxt = frame_r.seg[3];
          stop_nxt = 1'b1;
        end
        fdfb_pkg::IDX_ON: begin
          byte_nxt  = fdfb_pkg::CMD_ON | {5'd0, brightness};
          start_nxt = 1'b1;
          stop_nxt  = 1'b1;
          last_nxt  = 1'b1;
        end
        default: byte_nxt = '0;
      endcase
    end
  end

  // Control state: request held, position within it, output occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= fdfb_pkg::IDX_AUTO;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (frame_valid && frame_ready) begin
        busy_r <= 1'b1;
        idx_r  <= fdfb_pkg::IDX_AUTO;
      end else if (emit) begin
        if (last_step) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      frame_r <= frame;
    end
    if (emit) begin
      byte_r  <= byte_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_byte   = byte_r;
  assign out_chan.start_before = start_r;
  assign out_chan.stop_after   = stop_r;
  assign out_chan.error        = err_r;
  assign out_chan.last         = last_r;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the four-digit display frame builder: directed table, then random.
// Depends on fdfb_pkg (command bytes, codes) and fdfb_if (the channel interfaces).
`timescale 1ns / 1ps

module tb_top;
  import fdfb_pkg::*;

  // One expected or observed frame-byte item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       start_before;
    logic       stop_after;
    logic       error;
    logic       last;
  } disp_byte_t;

  // One row of the directed table. When typed is set, the segment bytes (first digit in the
  // top byte) and the error flag are given here instead of being predicted.
  typedef struct packed {
    logic               func;
    logic signed [15:0] number;
    logic        [1:0]  mode;
    logic               typed;
    logic               t_err;
    logic        [31:0] t_seg;
  } req_row_t;

  localparam int NUM_DIR     = 18;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  localparam req_row_t DIR_TABLE [NUM_DIR] = '{
    '{FUNC_SHOW,  16'sd0,      MODE_A, 1'b1, 1'b0, 32'h773F3F3F},
    '{FUNC_SHOW,  16'sd9999,   MODE_S, 1'b1, 1'b0, 32'h6D676767},
    '{FUNC_CLEAR, 16'sd32767,  MODE_S, 1'b1, 1'b0, 32'h00000000},
    '{FUNC_CLEAR, -16'sd32768, MODE_A, 1'b1, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  -16'sd1,     MODE_L, 1'b1, 1'b1, 32'h00000000},
    '{FUNC_SHOW,  16'sd10000,  MODE_E, 1'b1, 1'b1, 32'h00000000},
    '{FUNC_SHOW,  -16'sd32768, MODE_S, 1'b1, 1'b1, 32'h00000000},
    '{FUNC_SHOW,  16'sd32767,  MODE_A, 1'b1, 1'b1, 32'h00000000},
    '{FUNC_SHOW,  16'sd1234,   MODE_L, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd5678,   MODE_E, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd9,      MODE_A, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd10,     MODE_L, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd100,    MODE_E, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd1000,   MODE_S, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd9990,   MODE_S, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd4095,   MODE_A, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd8080,   MODE_L, 1'b0, 1'b0, 32'h00000000},
    '{FUNC_SHOW,  16'sd1,      MODE_E, 1'b0, 1'b0, 32'h00000000}
  };

  localparam logic [2:0] PHASE_BRIGHT [NUM_PHASES] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd7};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  fdfb_in_if  in_chan ();
  fdfb_out_if out_chan ();

  four_digit_display_frame_builder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  disp_byte_t frames_due [$];
  logic [2:0] bright_now;
  int         send_idle_pct;
  int         ready_idle_pct;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queue the items of one request from its segment bytes and error flag.
  function automatic void queue_frames(input logic err, input logic [31:0] segs,
                                       input logic [2:0] bright);
    if (err) begin
      frames_due.push_back('{8'h00, 1'b0, 1'b0, 1'b1, 1'b1});
    end else begin
      frames_due.push_back('{CMD_AUTO, 1'b1, 1'b1, 1'b0, 1'b0});
      frames_due.push_back('{CMD_ADDR, 1'b1, 1'b0, 1'b0, 1'b0});
      for (int i = 0; i < 4; i++) begin
        frames_due.push_back('{segs[31 - 8 * i -: 8], 1'b0, (i == 3), 1'b0, 1'b0});
      end
      frames_due.push_back('{CMD_ON | {5'b00000, bright}, 1'b1, 1'b1, 1'b0, 1'b1});
    end
  endfunction

  // Work out the segment bytes of a request and queue its items.
  function automatic void predict_frames(input logic f, input logic signed [15:0] n,
                                         input logic [1:0] m, input logic [2:0] bright);
    int         v;
    logic [7:0] letter;
    v = int'(n);
    letter = 8'h00;
    if (f == FUNC_CLEAR) begin
      // A clear ignores the number, so no range check applies.
      queue_frames(1'b0, 32'h00000000, bright);
    end else if (v < 0 || v > int'(NUM_MAX)) begin
      queue_frames(1'b1, 32'h00000000, bright);
    end else begin
      case (m)
        MODE_A: letter = 8'h77;
        MODE_L: letter = 8'h38;
        MODE_E: letter = 8'h79;
        MODE_S: letter = 8'h6D;
        default: letter = 8'h00;
      endcase
      // The thousands digit is dropped; the letter takes its place.
      queue_frames(1'b0, {letter, DIGIT_SEG[(v / 100) % 10], DIGIT_SEG[(v / 10) % 10],
                          DIGIT_SEG[v % 10]}, bright);
    end
  endfunction

  // Offer one request item after a random gap, and queue its items once it is taken.
  task automatic send_request(input logic f, input logic signed [15:0] n, input logic [1:0] m,
                              input logic typed, input logic t_err, input logic [31:0] t_seg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.func   <= f;
    in_chan.number <= n;
    in_chan.mode   <= m;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (typed) begin
      queue_frames(t_err, t_seg, bright_now);
    end else begin
      predict_frames(f, n, m, bright_now);
    end
  endtask

  // Mostly in-range shows, with clears, out-of-range numbers and edge values mixed in.
  task automatic send_random_request();
    logic               f;
    logic signed [15:0] n;
    logic        [1:0]  m;
    int                 pick;
    pick = $urandom_range(99);
    m = 2'($urandom_range(3));
    f = FUNC_SHOW;
    if (pick < 15) begin
      f = FUNC_CLEAR;
      n = 16'($urandom);
    end else if (pick < 25) begin
      n = 16'($urandom_range(32767, 10000));
    end else if (pick < 35) begin
      n = {1'b1, 15'($urandom)};
    end else if (pick < 45) begin
      n = ($urandom_range(1) == 1) ? 16'($urandom_range(9)) : 16'($urandom_range(9999, 9990));
    end else begin
      n = 16'($urandom_range(9999));
    end
    send_request(f, n, m, 1'b0, 1'b0, 32'h00000000);
  endtask

  // Stop offering items and wait until every queued item has come out.
  task automatic drain_frames();
    in_chan.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // Write the brightness register; the block is idle whenever this is called.
  task automatic write_brightness(input logic [2:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    bright_now = value;
    cfg_we    <= 1'b0;
  endtask

  // Receiver side: ready drops at random.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= ready_idle_pct);
    end
  end

  // Compare every accepted frame-byte item with the oldest one queued.
  always @(posedge clk) begin : check_frames
    disp_byte_t want;
    disp_byte_t got;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = '{out_chan.frame_byte, out_chan.start_before, out_chan.stop_after,
              out_chan.error, out_chan.last};
      if (frames_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected item: byte %h start %b stop %b error %b last %b",
                   got.frame_byte, got.start_before, got.stop_after, got.error, got.last);
        end
      end else begin
        want = frames_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected byte %h start %b stop %b error %b last %b",
                     want.frame_byte, want.start_before, want.stop_after, want.error,
                     want.last);
            $display("          actual   byte %h start %b stop %b error %b last %b",
                     got.frame_byte, got.start_before, got.stop_after, got.error, got.last);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases at several brightness levels.
  initial begin
    in_chan.valid  <= 1'b0;
    in_chan.func   <= FUNC_SHOW;
    in_chan.number <= 16'sd0;
    in_chan.mode   <= MODE_A;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 3'd0;
    rst_n          <= 1'b0;
    bright_now      = BRIGHT_RESET;
    send_idle_pct   = 34;
    ready_idle_pct  = 34;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run at the brightness left by reset.
    for (int r = 0; r < NUM_DIR; r++) begin
      send_request(DIR_TABLE[r].func, DIR_TABLE[r].number, DIR_TABLE[r].mode,
                   DIR_TABLE[r].typed, DIR_TABLE[r].t_err, DIR_TABLE[r].t_seg);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_frames();
      write_brightness((p == NUM_PHASES - 1) ? 3'($urandom_range(7)) : PHASE_BRIGHT[p]);
      // One phase runs with both sides always ready.
      send_idle_pct  = (p == 2) ? 0 : 34;
      ready_idle_pct = (p == 2) ? 0 : 34;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) begin
          drain_frames();
        end
        send_random_request();
      end
    end

    drain_frames();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
